[rtl/core/clamped_bspline_path_sampler_core_assert.svh]
// assertion macros for the clamped b-spline path sampler
// expects clk and rst_n in the scope of use
`ifndef CLAMPED_BSPLINE_PATH_SAMPLER_CORE_ASSERT_SVH
`define CLAMPED_BSPLINE_PATH_SAMPLER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBPS_ASSERT(lbl, prop, msg)
`define CBPS_ASSERT_IMP(lbl, ante, cons, msg)
`define CBPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/cbps_pkg.sv]
// shared types and constants of the clamped b-spline path sampler
// no dependencies
package cbps_pkg;

  localparam int COORD_W    = 32;
  localparam int DEG_W      = 2;
  localparam int SCNT_W     = 6;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int BASIS_BITS = 30;
  localparam int BASIS_W    = BASIS_BITS + 1;
  localparam int ACC_W      = 64;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int MUL_W      = 33;
  localparam int TDATA_W    = 3 * COORD_W;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DEGREE = 3;

  localparam logic [DEG_W-1:0]     DEF_DEGREE  = 2'd3;
  localparam logic [SCNT_W-1:0]    DEF_SAMPLES = 6'd32;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 1'b1;
  localparam logic [BASIS_W-1:0]   BASIS_ONE   = BASIS_W'(1) << BASIS_BITS;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SAMPLE_START,
    S_INIT,
    S_LVL_START,
    S_LVL_RD0,
    S_J_RD,
    S_J_NXT,
    S_A_MUL,
    S_A_DIV,
    S_A_WAIT,
    S_B_MUL,
    S_B_DIV,
    S_B_WAIT,
    S_WRITE,
    S_ACC_START,
    S_ACC_RD,
    S_ACC_MUL,
    S_ACC_ADD,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_EMIT,
    S_END_RD,
    S_END_EMIT,
    S_ERR
  } seq_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/cbps_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on cbps_pkg
module cbps_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cbps_pkg::div_req_t req,
  output cbps_pkg::div_rsp_t rsp
);
  import cbps_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_NUM_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[rtl/core/cbps_point_store.sv]
// control point memory, one write and one registered read port
// depends on cbps_pkg
module cbps_point_store #(
  parameter int DEPTH = cbps_pkg::DEF_MAX_POINTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cbps_pkg::point_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cbps_pkg::point_t         rdata
);
  import cbps_pkg::*;

  point_t mem [DEPTH];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/clamped_bspline_path_sampler_core.sv]
// clamped uniform b-spline path sampler; depends on cbps_pkg, cbps_div, cbps_point_store
// takes one control point request per cycle while loading; after the final point it works out
// each sample on the shared 64-step divider and then emits the end point, or only an error
// result; it takes no new points until the run is closed, and a result waits on out_tready;
// synchronous active-low reset clears control state; point and basis memories are not cleared
// and need no clearing pass
`include "clamped_bspline_path_sampler_core_assert.svh"

module clamped_bspline_path_sampler_core #(
  parameter int MAX_POINTS = cbps_pkg::DEF_MAX_POINTS,
  parameter int MAX_DEGREE = cbps_pkg::DEF_MAX_DEGREE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // control point requests
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cbps_pkg::TDATA_W-1:0]     in_tdata,   // point_x, point_y, point_z
  input  logic                             in_tlast,   // final_point
  // curve results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cbps_pkg::TDATA_W-1:0]     out_tdata,  // curve_x, curve_y, curve_z
  output logic                             out_tlast,  // end_of_path
  output logic [1:0]                       out_tuser,  // status
  // register writes
  input  logic                             cfg_we,
  input  logic [cbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbps_pkg::CFG_W-1:0]       cfg_wdata
);
  import cbps_pkg::*;

  localparam int PTR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = $clog2(MAX_DEGREE + 1);
  localparam int BD    = MAX_POINTS + MAX_DEGREE;
  localparam int BA_W  = $clog2(BD);
  localparam int JW    = $clog2(BD + 1);
  localparam int KW    = CNT_W + SCNT_W;

  // knot step: K(t+1) - K(t) is s inside the uniform part, zero in the clamped ends
  function automatic logic [KW-1:0] knot_inc(input int t, input int pv, input int nv,
                                             input logic [SCNT_W-1:0] sv);
    return (t >= pv && t < nv) ? KW'(sv) : '0;
  endfunction

  // register file
  logic [DEG_W-1:0]  degree_r, degree_nxt;
  logic [SCNT_W-1:0] samples_r, samples_nxt;

  // loading state
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              ovf_r, ovf_nxt;

  // sequencer
  seq_state_t        state_r, state_nxt;
  status_t           err_r, err_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [SCNT_W-1:0] s_r, s_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  m_r, m_nxt;
  logic [SCNT_W-1:0] i_r, i_nxt;
  logic [KW-1:0]     u_r, u_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [PW-1:0]     k_r, k_nxt;
  logic [1:0]        crd_r, crd_nxt;

  // knot walkers: K(j), K(j+1), K(j+k), K(j+k+1)
  logic [KW-1:0]     kj_r, kj_nxt, kj1_r, kj1_nxt, kjk_r, kjk_nxt, kjk1_r, kjk1_nxt;

  // basis and accumulation datapath
  logic [BASIS_W-1:0]     cur_r, cur_nxt, nxt_r, nxt_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic [DIV_DEN_W-1:0]   w_r, w_nxt;
  logic [COORD_W-1:0]     res_r [3];
  logic [COORD_W-1:0]     res_nxt [3];

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_full;
  logic signed [ACC_W-1:0]   prod_r;

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // basis memory
  logic [BASIS_W-1:0] basis_mem [BD];
  logic               bm_we, bm_re;
  logic [BA_W-1:0]    bm_waddr, bm_raddr;
  logic [BASIS_W-1:0] bm_wdata, bm_rdata_r;

  // point store ports
  logic               st_we, st_re;
  logic [PTR_W-1:0]   st_waddr, st_raddr;
  point_t             st_wdata, st_rdata;

  // output register
  logic               out_valid_r, out_valid_nxt;
  point_t             out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_load, out_free;

  // combinational helpers
  logic               in_acc, wrote;
  logic [CNT_W-1:0]   n_fin;
  logic               ov_fin;
  logic [PW-1:0]      deg_eff;
  logic [JW-1:0]      j_inc;
  logic [CNT_W-1:0]   nm1;
  logic [KW-1:0]      num1, num2;
  logic signed [COORD_W-1:0] coord_sel;
  logic signed [ACC_W-1:0]   acc_sel;
  logic [ACC_W-1:0]   mag;
  logic [COORD_W-1:0] mean_q;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign wrote     = held_r < CNT_W'(MAX_POINTS);
  assign n_fin     = wrote ? held_r + CNT_W'(1) : held_r;
  assign ov_fin    = ovf_r || !wrote;
  assign j_inc     = j_r + JW'(1);
  assign nm1       = n_r - CNT_W'(1);
  assign num1      = (u_r >= kj_r) ? u_r - kj_r : '0;
  assign num2      = (kjk1_r >= u_r) ? kjk1_r - u_r : '0;
  assign acc_sel   = acc_r[crd_r];
  assign mag       = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);

  // degree out of range: zero acts as one, large values saturate
  always_comb begin
    if (degree_r == '0) begin
      deg_eff = PW'(1);
    end else if (int'(degree_r) > MAX_DEGREE) begin
      deg_eff = PW'(MAX_DEGREE);
    end else begin
      deg_eff = PW'(degree_r);
    end
  end

  always_comb begin
    case (crd_r)
      2'd0:    coord_sel = $signed(st_rdata.x);
      2'd1:    coord_sel = $signed(st_rdata.y);
      default: coord_sel = $signed(st_rdata.z);
    endcase
  end

  // rounded quotient, saturated to 32 bits with the sign of the sum
  always_comb begin
    if (acc_sel[ACC_W-1]) begin
      if (div_rsp.quotient > ACC_W'(64'h8000_0000)) begin
        mean_q = 32'h8000_0000;
      end else begin
        mean_q = COORD_W'(-div_rsp.quotient);
      end
    end else begin
      if (div_rsp.quotient > ACC_W'(64'h7FFF_FFFF)) begin
        mean_q = 32'h7FFF_FFFF;
      end else begin
        mean_q = div_rsp.quotient[COORD_W-1:0];
      end
    end
  end

  // shared multiplier, result registered before use
  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_full[ACC_W-1:0];
  end

  // sequencer: next state and datapath control
  always_comb begin
    degree_nxt  = degree_r;
    samples_nxt = samples_r;
    held_nxt    = held_r;
    ovf_nxt     = ovf_r;
    state_nxt   = state_r;
    err_nxt     = err_r;
    p_nxt       = p_r;
    s_nxt       = s_r;
    n_nxt       = n_r;
    m_nxt       = m_r;
    i_nxt       = i_r;
    u_nxt       = u_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    crd_nxt     = crd_r;
    kj_nxt      = kj_r;
    kj1_nxt     = kj1_r;
    kjk_nxt     = kjk_r;
    kjk1_nxt    = kjk1_r;
    cur_nxt     = cur_r;
    nxt_nxt     = nxt_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    acc_nxt     = acc_r;
    w_nxt       = w_r;
    res_nxt     = res_r;

    mul_a       = $signed(MUL_W'(cur_r));
    mul_b       = MUL_W'(coord_sel);
    div_req     = '0;

    bm_we       = 1'b0;
    bm_waddr    = j_r[BA_W-1:0];
    bm_wdata    = '0;
    bm_re       = 1'b0;
    bm_raddr    = j_r[BA_W-1:0];

    st_we       = 1'b0;
    st_waddr    = held_r[PTR_W-1:0];
    st_wdata    = point_t'(in_tdata);
    st_re       = 1'b0;
    st_raddr    = j_r[PTR_W-1:0];

    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    // writes land at once; a run works on the values latched at its final point
    if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE:  degree_nxt  = cfg_wdata[DEG_W-1:0];
        REG_SAMPLES: samples_nxt = cfg_wdata[SCNT_W-1:0];
        default:     ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (wrote) begin
            st_we    = 1'b1;
            held_nxt = held_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            // end of set: latch geometry, clear the loader
            held_nxt = '0;
            ovf_nxt  = 1'b0;
            p_nxt    = deg_eff;
            s_nxt    = samples_r;
            n_nxt    = n_fin;
            m_nxt    = CNT_W'(int'(n_fin) - int'(deg_eff));
            i_nxt    = '0;
            u_nxt    = '0;
            if (ov_fin) begin
              err_nxt   = ST_OVF;
              state_nxt = S_ERR;
            end else if (int'(n_fin) < int'(deg_eff) + 1) begin
              err_nxt   = ST_FEW;
              state_nxt = S_ERR;
            end else if (samples_r == '0) begin
              state_nxt = S_END_RD;
            end else begin
              state_nxt = S_SAMPLE_START;
            end
          end
        end
      end

      S_SAMPLE_START: begin
        j_nxt     = '0;
        kj_nxt    = '0;
        kj1_nxt   = '0;
        state_nxt = S_INIT;
      end

      // degree-zero basis: one over the half-open span that holds u
      S_INIT: begin
        bm_we    = 1'b1;
        bm_wdata = (kj_r <= u_r && u_r < kj1_r) ? BASIS_ONE : '0;
        kj_nxt   = kj1_r;
        kj1_nxt  = kj1_r + knot_inc(int'(j_r) + 1, int'(p_r), int'(n_r), s_r);
        if (int'(j_r) == int'(n_r) + int'(p_r) - 1) begin
          k_nxt     = PW'(1);
          state_nxt = S_LVL_START;
        end else begin
          j_nxt = j_inc;
        end
      end

      S_LVL_START: begin
        j_nxt     = '0;
        kj_nxt    = '0;
        kj1_nxt   = '0;
        kjk_nxt   = '0;
        kjk1_nxt  = (k_r == p_r) ? KW'(s_r) : '0;
        bm_re     = 1'b1;
        bm_raddr  = '0;
        state_nxt = S_LVL_RD0;
      end

      S_LVL_RD0: begin
        cur_nxt   = bm_rdata_r;
        state_nxt = S_J_RD;
      end

      S_J_RD: begin
        bm_re     = 1'b1;
        bm_raddr  = j_inc[BA_W-1:0];
        state_nxt = S_J_NXT;
      end

      S_J_NXT: begin
        nxt_nxt   = bm_rdata_r;
        state_nxt = S_A_MUL;
      end

      // left term: (u - K(j)) * N(j) / (K(j+k) - K(j))
      S_A_MUL: begin
        mul_a = $signed(MUL_W'(num1));
        mul_b = $signed(MUL_W'(cur_r));
        if (cur_r != '0 && kjk_r != kj_r) begin
          state_nxt = S_A_DIV;
        end else begin
          a_nxt     = '0;
          state_nxt = S_B_MUL;
        end
      end

      S_A_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(prod_r);
        div_req.divisor  = DIV_DEN_W'(kjk_r - kj_r);
        state_nxt        = S_A_WAIT;
      end

      S_A_WAIT: begin
        if (div_rsp.done) begin
          a_nxt     = div_rsp.quotient[BASIS_W-1:0];
          state_nxt = S_B_MUL;
        end
      end

      // right term: (K(j+k+1) - u) * N(j+1) / (K(j+k+1) - K(j+1))
      S_B_MUL: begin
        mul_a = $signed(MUL_W'(num2));
        mul_b = $signed(MUL_W'(nxt_r));
        if (nxt_r != '0 && kjk1_r != kj1_r) begin
          state_nxt = S_B_DIV;
        end else begin
          b_nxt     = '0;
          state_nxt = S_WRITE;
        end
      end

      S_B_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(prod_r);
        div_req.divisor  = DIV_DEN_W'(kjk1_r - kj1_r);
        state_nxt        = S_B_WAIT;
      end

      S_B_WAIT: begin
        if (div_rsp.done) begin
          b_nxt     = div_rsp.quotient[BASIS_W-1:0];
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        bm_we    = 1'b1;
        bm_wdata = BASIS_W'(a_r + b_r);
        cur_nxt  = nxt_r;
        kj_nxt   = kj1_r;
        kj1_nxt  = kj1_r + knot_inc(int'(j_r) + 1, int'(p_r), int'(n_r), s_r);
        kjk_nxt  = kjk1_r;
        kjk1_nxt = kjk1_r + knot_inc(int'(j_r) + int'(k_r) + 1, int'(p_r), int'(n_r), s_r);
        if (int'(j_r) == int'(n_r) + int'(p_r) - int'(k_r) - 1) begin
          if (k_r == p_r) begin
            state_nxt = S_ACC_START;
          end else begin
            k_nxt     = k_r + PW'(1);
            state_nxt = S_LVL_START;
          end
        end else begin
          j_nxt     = j_inc;
          state_nxt = S_J_RD;
        end
      end

      S_ACC_START: begin
        j_nxt      = '0;
        w_nxt      = '0;
        acc_nxt[0] = '0;
        acc_nxt[1] = '0;
        acc_nxt[2] = '0;
        bm_re      = 1'b1;
        bm_raddr   = '0;
        st_re      = 1'b1;
        st_raddr   = '0;
        state_nxt  = S_ACC_RD;
      end

      S_ACC_RD: begin
        cur_nxt   = bm_rdata_r;
        w_nxt     = w_r + DIV_DEN_W'(bm_rdata_r);
        crd_nxt   = '0;
        state_nxt = S_ACC_MUL;
      end

      S_ACC_MUL: begin
        state_nxt = S_ACC_ADD;
      end

      S_ACC_ADD: begin
        acc_nxt[crd_r] = acc_r[crd_r] + prod_r;
        if (crd_r == 2'd2) begin
          crd_nxt = '0;
          if (int'(j_r) == int'(n_r) - 1) begin
            state_nxt = S_MEAN_START;
          end else begin
            j_nxt     = j_inc;
            bm_re     = 1'b1;
            bm_raddr  = j_inc[BA_W-1:0];
            st_re     = 1'b1;
            st_raddr  = j_inc[PTR_W-1:0];
            state_nxt = S_ACC_RD;
          end
        end else begin
          crd_nxt   = crd_r + 2'd1;
          state_nxt = S_ACC_MUL;
        end
      end

      // weighted mean, rounded half away from zero
      S_MEAN_START: begin
        if (w_r == '0) begin
          res_nxt[crd_r] = '0;
          if (crd_r == 2'd2) begin
            state_nxt = S_EMIT;
          end else begin
            crd_nxt = crd_r + 2'd1;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = mag + ACC_W'(w_r >> 1);
          div_req.divisor  = w_r;
          state_nxt        = S_MEAN_WAIT;
        end
      end

      S_MEAN_WAIT: begin
        if (div_rsp.done) begin
          res_nxt[crd_r] = mean_q;
          if (crd_r == 2'd2) begin
            state_nxt = S_EMIT;
          end else begin
            crd_nxt   = crd_r + 2'd1;
            state_nxt = S_MEAN_START;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_nxt   = '{z: res_r[2], y: res_r[1], x: res_r[0]};
          out_last_nxt   = 1'b0;
          out_status_nxt = ST_OK;
          if (i_r + SCNT_W'(1) == s_r) begin
            state_nxt = S_END_RD;
          end else begin
            i_nxt     = i_r + SCNT_W'(1);
            u_nxt     = u_r + KW'(m_r);
            state_nxt = S_SAMPLE_START;
          end
        end
      end

      S_END_RD: begin
        st_re     = 1'b1;
        st_raddr  = nm1[PTR_W-1:0];
        state_nxt = S_END_EMIT;
      end

      S_END_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_nxt   = st_rdata;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = err_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // accumulate step multiplies the stored coordinate by its basis weight
    if (state_r == S_ACC_MUL) begin
      mul_a = $signed(MUL_W'(cur_r));
      mul_b = MUL_W'(coord_sel);
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= DEF_DEGREE;
      samples_r   <= DEF_SAMPLES;
      held_r      <= '0;
      ovf_r       <= 1'b0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      degree_r    <= degree_nxt;
      samples_r   <= samples_nxt;
      held_r      <= held_nxt;
      ovf_r       <= ovf_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and loop registers
  always_ff @(posedge clk) begin
    err_r        <= err_nxt;
    p_r          <= p_nxt;
    s_r          <= s_nxt;
    n_r          <= n_nxt;
    m_r          <= m_nxt;
    i_r          <= i_nxt;
    u_r          <= u_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    crd_r        <= crd_nxt;
    kj_r         <= kj_nxt;
    kj1_r        <= kj1_nxt;
    kjk_r        <= kjk_nxt;
    kjk1_r       <= kjk1_nxt;
    cur_r        <= cur_nxt;
    nxt_r        <= nxt_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    w_r          <= w_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  // basis memory
  always_ff @(posedge clk) begin
    if (bm_we) begin
      basis_mem[bm_waddr] <= bm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_re) begin
      bm_rdata_r <= basis_mem[bm_raddr];
    end
  end

  cbps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cbps_point_store #(
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // checks on the sequencer and datapath
  `CBPS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `CBPS_ASSERT_IMP(a_basis_bound, bm_we, bm_wdata <= BASIS_ONE, "basis value above one")
  `CBPS_ASSERT_NXT(a_last_to_idle, out_load && out_last_nxt, state_r == S_IDLE, "run not closed")
  `CBPS_ASSERT(a_held_bound, held_r <= CNT_W'(MAX_POINTS), "point count beyond store")

endmodule
